[rtl/core/stable_priority_queue_top_macros.svh]
// ---------------------------------------------------------------------------
// Stable priority queue assertion macros
// Shared concurrent assertion forms, clocked on clk_i, off during reset.
// ---------------------------------------------------------------------------
`ifndef STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH
`define STABLE_PRIORITY_QUEUE_TOP_MACROS_SVH

// property holds at every edge
`define SPQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// antecedent implies consequent in the next cycle
`define SPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/core/spq_pkg.sv]
// ---------------------------------------------------------------------------
// Stable priority queue package
// Beat types, operation and status codes, default parameter values.
// ---------------------------------------------------------------------------
package spq_pkg;

  localparam int unsigned CapacityDef  = 16;
  localparam int unsigned DataWidthDef = 32;
  localparam int unsigned PrioWidth    = 16;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_POP    = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]           operation;
    logic [31:0]          entry_data;
    logic [PrioWidth-1:0] entry_priority;
  } spq_in_t;

  typedef struct packed {
    logic [31:0] out_data;
    logic [1:0]  status;
    logic [4:0]  occupancy;
  } spq_out_t;

endpackage

[rtl/core/spq_store.sv]
// ---------------------------------------------------------------------------
// Stable priority queue entry store
// Single write port, single registered read port.
// ---------------------------------------------------------------------------
module spq_store import spq_pkg::*; #(
  parameter int unsigned Depth = CapacityDef,
  parameter int unsigned Width = DataWidthDef + PrioWidth
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/core/stable_priority_queue_top.sv]
// ---------------------------------------------------------------------------
// Stable priority queue
// Bounded priority queue, equal priorities leave in arrival order.
// ---------------------------------------------------------------------------
// One beat is taken when start_i is high and busy_o is low; each beat yields
// exactly one result beat on result_o, marked by done_o for one cycle, and
// the receiver cannot stall it. Clear, ignored codes, an insert into a full
// queue and a pop on an empty queue return their result the next cycle
// without raising busy_o. A pop raises busy_o in its pop state and returns
// as busy_o falls. An insert walks the queue from the tail through the entry
// store and its registered read port, a read state then a compare state per
// entry, moving each entry below the new priority one place toward the tail;
// it examines at most the stored entries and returns as busy_o falls. The
// store is a ring with a head pointer, so a pop needs no shifting.
// ---------------------------------------------------------------------------
module stable_priority_queue_top import spq_pkg::*; #(
  parameter int unsigned CAPACITY   = CapacityDef,
  parameter int unsigned DATA_WIDTH = DataWidthDef
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  spq_in_t  in_i,
  output logic     busy_o,
  output logic     done_o,
  output spq_out_t result_o
);

`include "stable_priority_queue_top_macros.svh"

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = DATA_WIDTH + PrioWidth;
  localparam logic [AW-1:0] LastIdx = AW'(CAPACITY - 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_CMP  = 3'd2;
  localparam logic [2:0] S_PUT  = 3'd3;
  localparam logic [2:0] S_POP  = 3'd4;

  logic [2:0]            state_q, state_d;
  logic [AW-1:0]         head_q, head_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         left_q, left_d;
  logic [AW-1:0]         wr_ptr_q, wr_ptr_d;
  logic [AW-1:0]         rd_ptr_q, rd_ptr_d;
  logic [DATA_WIDTH-1:0] new_data_q, new_data_d;
  logic [PrioWidth-1:0]  new_prio_q, new_prio_d;
  logic                  done_q, done_d;
  spq_out_t              res_q, res_d;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [EW-1:0]         mem_wdata;
  logic [AW-1:0]         mem_raddr;
  logic [EW-1:0]         mem_rdata;

  logic                  accept;
  logic [AW:0]           tail_sum;
  logic [AW-1:0]         tail;
  logic [DATA_WIDTH+31:0] in_wide;
  logic [DATA_WIDTH+31:0] out_wide;
  logic [CW+4:0]         occ_wide;
  logic [DATA_WIDTH-1:0] rd_data;
  logic [PrioWidth-1:0]  rd_prio;

  function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
    return (p == LastIdx) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [AW-1:0] ptr_dec(input logic [AW-1:0] p);
    return (p == '0) ? LastIdx : p - 1'b1;
  endfunction

  assign accept   = start_i && (state_q == S_IDLE);
  assign tail_sum = (AW+1)'(head_q) + (AW+1)'(count_q);
  assign tail     = (tail_sum >= (AW+1)'(CAPACITY)) ? AW'(tail_sum - (AW+1)'(CAPACITY))
                                                    : AW'(tail_sum);
  assign in_wide  = {{DATA_WIDTH{1'b0}}, in_i.entry_data};
  assign rd_data  = mem_rdata[DATA_WIDTH-1:0];
  assign rd_prio  = mem_rdata[EW-1:DATA_WIDTH];
  assign out_wide = {32'd0, rd_data};
  assign occ_wide = {5'd0, count_d};
  assign mem_raddr = (state_q == S_IDLE) ? head_q : rd_ptr_q;

  always_comb begin
    state_d    = state_q;
    head_d     = head_q;
    count_d    = count_q;
    left_d     = left_q;
    wr_ptr_d   = wr_ptr_q;
    rd_ptr_d   = rd_ptr_q;
    new_data_d = new_data_q;
    new_prio_d = new_prio_q;
    done_d     = 1'b0;
    res_d      = res_q;
    mem_we     = 1'b0;
    mem_waddr  = wr_ptr_q;
    mem_wdata  = {new_prio_q, new_data_q};

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          res_d.out_data = '0;
          res_d.status   = ST_OK;
          case (in_i.operation)
            OP_INSERT: begin
              if (count_q >= CW'(CAPACITY)) begin
                done_d       = 1'b1;
                res_d.status = ST_FULL;
              end else begin
                new_data_d = in_wide[DATA_WIDTH-1:0];
                new_prio_d = in_i.entry_priority;
                wr_ptr_d   = tail;
                rd_ptr_d   = ptr_dec(tail);
                left_d     = count_q;
                state_d    = (count_q == '0) ? S_PUT : S_RD;
              end
            end
            OP_POP: begin
              if (count_q == '0) begin
                done_d       = 1'b1;
                res_d.status = ST_EMPTY;
              end else begin
                state_d = S_POP;
              end
            end
            OP_CLEAR: begin
              count_d = '0;
              done_d  = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end
      S_RD: begin
        state_d = S_CMP;
      end
      S_CMP: begin
        if (rd_prio >= new_prio_q) begin
          state_d = S_PUT;
        end else begin
          mem_we    = 1'b1;
          mem_wdata = mem_rdata;
          wr_ptr_d  = rd_ptr_q;
          left_d    = left_q - 1'b1;
          if (left_q == CW'(1)) begin
            state_d = S_PUT;
          end else begin
            rd_ptr_d = ptr_dec(rd_ptr_q);
            state_d  = S_RD;
          end
        end
      end
      S_PUT: begin
        mem_we         = 1'b1;
        count_d        = count_q + 1'b1;
        done_d         = 1'b1;
        res_d.out_data = '0;
        res_d.status   = ST_OK;
        state_d        = S_IDLE;
      end
      S_POP: begin
        head_d         = ptr_inc(head_q);
        count_d        = count_q - 1'b1;
        done_d         = 1'b1;
        res_d.out_data = out_wide[31:0];
        res_d.status   = ST_OK;
        state_d        = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    res_d.occupancy = occ_wide[4:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      head_q  <= '0;
      count_q <= '0;
      left_q  <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      head_q  <= head_d;
      count_q <= count_d;
      left_q  <= left_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wr_ptr_q   <= wr_ptr_d;
    rd_ptr_q   <= rd_ptr_d;
    new_data_q <= new_data_d;
    new_prio_q <= new_prio_d;
    res_q      <= res_d;
  end

  spq_store #(
    .Depth(CAPACITY),
    .Width(EW)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  assign busy_o   = (state_q != S_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  `SPQ_ASSERT(a_count_bound, count_q <= CW'(CAPACITY), "occupancy above capacity")
  `SPQ_ASSERT(a_done_idle, !done_o || !busy_o, "result beat while busy")
  `SPQ_ASSERT(a_cmp_left, (state_q != S_CMP) || (left_q != '0), "insert walk past head")
  `SPQ_ASSERT_NEXT(a_pop_seq,
                   accept && (in_i.operation == OP_POP) && (count_q != '0),
                   state_q == S_POP, "pop did not enter pop state")
  `SPQ_ASSERT_NEXT(a_put_done, state_q == S_PUT,
                   done_o && (count_q == $past(count_q) + 1'b1), "insert did not complete")

endmodule
